// ===== rtl/precedence_check_and_topo_sort_core_macros.svh =====
// Assertion macros for the precedence check and topological sort core
`ifndef PRECEDENCE_CHECK_AND_TOPO_SORT_CORE_MACROS_SVH
`define PRECEDENCE_CHECK_AND_TOPO_SORT_CORE_MACROS_SVH

// same-cycle implication
`define PCTS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pcts: assertion failed");

// next-cycle implication
`define PCTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pcts: assertion failed");

`endif

// ===== rtl/pcts_pkg.sv =====
// Package: shared constants and types of the precedence check and sort core
`timescale 1ns / 1ps
package pcts_pkg;

    localparam int PAGE_COUNT_DEF     = 128;
    localparam int MAX_UPDATE_LEN_DEF = 32;
    localparam int PAGE_W             = 7;
    localparam int S_DATA_W           = 24;
    localparam int M_DATA_W           = 16;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_DUP  = 11'b000_0000_0010,
        S_CLR  = 11'b000_0000_0100,
        S_ROWA = 11'b000_0000_1000,
        S_ROWB = 11'b000_0001_0000,
        S_PAIR = 11'b000_0010_0000,
        S_SRCH = 11'b000_0100_0000,
        S_PICK = 11'b000_1000_0000,
        S_PROW = 11'b001_0000_0000,
        S_DEC  = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } t_state;

    typedef struct packed {
        logic              en;
        logic [PAGE_W-1:0] row;
        logic [PAGE_W-1:0] col;
    } t_rule_wr;

    typedef struct packed {
        logic              en;
        logic [PAGE_W-1:0] row;
    } t_rule_rd;

endpackage

// ===== rtl/pcts_rule_mem.sv =====
// Precedence matrix: one row per page, row valid bits cleared at reset
`timescale 1ns / 1ps
module pcts_rule_mem #(
    parameter int PAGE_COUNT = pcts_pkg::PAGE_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pcts_pkg::t_rule_wr    i_wr,
    input  pcts_pkg::t_rule_rd    i_rd,
    output logic [PAGE_COUNT-1:0] o_row
);
    import pcts_pkg::*;

    localparam int PW = $clog2(PAGE_COUNT);

    logic [PAGE_COUNT-1:0] m_rows [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] r_vld;
    logic [PAGE_COUNT-1:0] r_row;
    logic                  wr_ok;
    logic [PW-1:0]         wr_r;
    logic [PW-1:0]         wr_c;
    logic [PW-1:0]         rd_r;

    assign wr_ok = i_wr.en && (32'(i_wr.row) < PAGE_COUNT) && (32'(i_wr.col) < PAGE_COUNT);
    assign wr_r  = PW'(i_wr.row);
    assign wr_c  = PW'(i_wr.col);
    assign rd_r  = PW'(i_rd.row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_ok) begin
            r_vld[wr_r] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            if (r_vld[wr_r]) begin
                m_rows[wr_r][wr_c] <= 1'b1;
            end else begin
                m_rows[wr_r] <= {{(PAGE_COUNT-1){1'b0}}, 1'b1} << wr_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_row <= r_vld[rd_r] ? m_rows[rd_r] : '0;
        end
    end

    assign o_row = r_row;

endmodule

// ===== rtl/precedence_check_and_topo_sort_core.sv =====
// Top level: rule loading, update intake, order check and Kahn sort
//
// Input stream (i_s_*): tuser 0 loads a rule (before_page must precede
// after_page), tuser 1 appends a page to the current update; tlast on a
// page closes the update. A rule item is written into the matrix on
// acceptance. A page item scans the stored pages for a duplicate. On the
// closing page the block checks the given order and counts predecessors,
// then for each placed page searches for one with no pending predecessor
// and updates the counts of its successors, all on one shared
// compare/count datapath and the pending-count memory port.
// Output stream (o_m_*): one item per placed page in sorted order, tlast on
// the final one; a single empty item when nothing was placed.
// o_s_tready is high only while the block is idle. A stalled receiver holds
// the output register and the sequencer waits on it.
// Reset clears the rule matrix (per-row valid bits), the update length and
// the error flag at once; no clearing pass is needed.
`timescale 1ns / 1ps
module precedence_check_and_topo_sort_core #(
    parameter int PAGE_COUNT     = pcts_pkg::PAGE_COUNT_DEF,
    parameter int MAX_UPDATE_LEN = pcts_pkg::MAX_UPDATE_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [pcts_pkg::S_DATA_W-1:0] i_s_tdata,  // before_page, after_page, page, 0
    input  logic                          i_s_tuser,  // req_type
    input  logic                          i_s_tlast,  // last_page
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [pcts_pkg::M_DATA_W-1:0] o_m_tdata,  // sorted_page, in_order, complete, 0
    output logic                          o_m_tuser,  // page_valid
    output logic                          o_m_tlast   // last
);
    import pcts_pkg::*;

    localparam int PW = $clog2(PAGE_COUNT);
    localparam int LW = $clog2(MAX_UPDATE_LEN);
    localparam int CW = $clog2(MAX_UPDATE_LEN + 1);

    t_state               r_state;
    logic                 r_ph;
    logic [CW-1:0]        r_len;
    logic                 r_err;
    logic                 r_ord;
    logic [PAGE_W-1:0]    r_page;
    logic                 r_last;
    logic                 r_dup;
    logic [CW-1:0]        r_i;
    logic [CW-1:0]        r_b;
    logic [CW-1:0]        r_np;
    logic [CW-1:0]        r_k;
    logic [LW-1:0]        r_pick;
    logic [PAGE_W-1:0]    r_pa;
    logic [MAX_UPDATE_LEN-1:0] r_placed;

    logic [PAGE_W-1:0]    m_pages [MAX_UPDATE_LEN];
    logic [CW-1:0]        m_pend  [MAX_UPDATE_LEN];
    logic [PAGE_W-1:0]    m_order [MAX_UPDATE_LEN];
    logic [PAGE_W-1:0]    r_pg_rd;
    logic [CW-1:0]        r_pc_rd;
    logic [PAGE_W-1:0]    r_or_rd;

    logic                 r_ov;
    logic [PAGE_W-1:0]    r_o_page;
    logic                 r_o_pv;
    logic                 r_o_ord;
    logic                 r_o_comp;
    logic                 r_o_last;

    t_rule_wr             rule_wr;
    t_rule_rd             rule_rd;
    logic [PAGE_COUNT-1:0] row;

    logic                 s_acc;
    logic                 out_free;
    logic                 bit_hit;
    logic                 comp;
    logic [LW-1:0]        pg_ra;
    logic [LW-1:0]        pc_ra;
    logic                 pg_we;
    logic                 pc_we;
    logic [LW-1:0]        pc_wa;
    logic [CW-1:0]        n_pc;
    logic                 or_we;
    logic                 bad;

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_free = !r_ov || i_m_tready;
    assign bit_hit  = row[PW'(r_pg_rd)];
    assign comp     = !r_err && (r_np == r_len);
    assign bad      = r_dup || (32'(r_page) >= PAGE_COUNT) ||
                      (r_len == CW'(MAX_UPDATE_LEN));

    assign rule_wr.en  = s_acc && !i_s_tuser;
    assign rule_wr.row = i_s_tdata[6:0];
    assign rule_wr.col = i_s_tdata[13:7];
    assign rule_rd.en  = (r_state == S_ROWB) || (r_state == S_PROW);
    assign rule_rd.row = r_pa;

    pcts_rule_mem #(.PAGE_COUNT(PAGE_COUNT)) u_rule_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (rule_wr),
        .i_rd    (rule_rd),
        .o_row   (row)
    );

    always_comb begin
        pg_ra = r_b[LW-1:0];
        pc_ra = r_b[LW-1:0];
        pg_we = 1'b0;
        pc_we = 1'b0;
        pc_wa = r_b[LW-1:0];
        n_pc  = '0;
        or_we = 1'b0;
        case (r_state)
            S_DUP: begin
                pg_ra = r_i[LW-1:0];
                pg_we = (r_i == r_len) && !bad;
            end
            S_CLR: begin
                pc_wa = r_i[LW-1:0];
                pc_we = (r_i != r_len);
            end
            S_ROWA: begin
                pg_ra = r_i[LW-1:0];
            end
            S_PAIR: begin
                pc_we = (r_b != r_len) && r_ph;
                n_pc  = r_pc_rd + CW'(bit_hit);
            end
            S_SRCH: begin
                pc_ra = r_i[LW-1:0];
            end
            S_PICK: begin
                pg_ra = r_pick;
                or_we = r_ph;
            end
            S_DEC: begin
                pc_we = (r_b != r_len) && r_ph && !r_placed[r_b[LW-1:0]] &&
                        (r_pc_rd != '0) && bit_hit;
                n_pc  = r_pc_rd - CW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pg_rd <= m_pages[pg_ra];
        r_pc_rd <= m_pend[pc_ra];
        r_or_rd <= m_order[r_k[LW-1:0]];
        if (pg_we) begin
            m_pages[r_len[LW-1:0]] <= r_page;
        end
        if (pc_we) begin
            m_pend[pc_wa] <= n_pc;
        end
        if (or_we) begin
            m_order[r_np[LW-1:0]] <= r_pg_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 1'b0;
            r_len   <= '0;
            r_err   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc && i_s_tuser) begin
                        r_page  <= i_s_tdata[20:14];
                        r_last  <= i_s_tlast;
                        r_dup   <= 1'b0;
                        r_i     <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_DUP;
                    end
                end
                S_DUP: begin
                    if (r_i == r_len) begin
                        if (bad) begin
                            r_err <= 1'b1;
                        end else begin
                            r_len <= r_len + CW'(1);
                        end
                        r_i      <= '0;
                        r_ord    <= 1'b1;
                        r_placed <= '0;
                        r_state  <= r_last ? S_CLR : S_IDLE;
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        if (r_pg_rd == r_page) begin
                            r_dup <= 1'b1;
                        end
                        r_i  <= r_i + CW'(1);
                        r_ph <= 1'b0;
                    end
                end
                S_CLR: begin
                    if (r_i == r_len) begin
                        r_i     <= '0;
                        r_state <= S_ROWA;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_ROWA: begin
                    if (r_i == r_len) begin
                        r_i     <= '0;
                        r_np    <= '0;
                        r_state <= S_SRCH;
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_pa    <= r_pg_rd;
                        r_ph    <= 1'b0;
                        r_state <= S_ROWB;
                    end
                end
                S_ROWB: begin
                    r_b     <= '0;
                    r_state <= S_PAIR;
                end
                S_PAIR: begin
                    if (r_b == r_len) begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_ROWA;
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        if (bit_hit && (r_b < r_i)) begin
                            r_ord <= 1'b0;
                        end
                        r_b  <= r_b + CW'(1);
                        r_ph <= 1'b0;
                    end
                end
                S_SRCH: begin
                    if (r_i == r_len) begin
                        r_k     <= '0;
                        r_state <= S_OUT;
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (!r_placed[r_i[LW-1:0]] && (r_pc_rd == '0)) begin
                            r_placed[r_i[LW-1:0]] <= 1'b1;
                            r_pick  <= r_i[LW-1:0];
                            r_state <= S_PICK;
                        end else begin
                            r_i <= r_i + CW'(1);
                        end
                    end
                end
                S_PICK: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_pa    <= r_pg_rd;
                        r_np    <= r_np + CW'(1);
                        r_ph    <= 1'b0;
                        r_state <= S_PROW;
                    end
                end
                S_PROW: begin
                    r_b     <= '0;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (r_b == r_len) begin
                        r_i     <= '0;
                        r_state <= S_SRCH;
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_b  <= r_b + CW'(1);
                        r_ph <= 1'b0;
                    end
                end
                S_OUT: begin
                    if (r_np == '0) begin
                        if (out_free) begin
                            r_ov     <= 1'b1;
                            r_o_page <= '0;
                            r_o_pv   <= 1'b0;
                            r_o_ord  <= r_ord;
                            r_o_comp <= comp;
                            r_o_last <= 1'b1;
                            r_len    <= '0;
                            r_err    <= 1'b0;
                            r_state  <= S_IDLE;
                        end
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (out_free) begin
                        r_ov     <= 1'b1;
                        r_o_page <= r_or_rd;
                        r_o_pv   <= 1'b1;
                        r_o_ord  <= r_ord;
                        r_o_comp <= comp;
                        r_o_last <= (r_k + CW'(1)) == r_np;
                        r_k      <= r_k + CW'(1);
                        r_ph     <= 1'b0;
                        if ((r_k + CW'(1)) == r_np) begin
                            r_len   <= '0;
                            r_err   <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {{(M_DATA_W-PAGE_W-2){1'b0}}, r_o_comp, r_o_ord, r_o_page};
    assign o_m_tuser  = r_o_pv;
    assign o_m_tlast  = r_o_last;

endmodule

// ===== rtl/pcts_checker.sv =====
// Port checker for the precedence check and sort core, with its bind
`timescale 1ns / 1ps
`include "precedence_check_and_topo_sort_core_macros.svh"
module pcts_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          i_s_tuser,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [pcts_pkg::M_DATA_W-1:0] o_m_tdata,
    input logic                          o_m_tuser,
    input logic                          o_m_tlast
);
    // stalled item holds
    `PCTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    // a rule item never starts an output
    `PCTS_ASSERT_NEXT(a_rule_quiet, i_clk, i_rst_n, i_s_tvalid && o_s_tready && !i_s_tuser, !$rose(o_m_tvalid))
    // empty result is the only item of its update
    `PCTS_ASSERT_NOW(a_empty_last, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tlast)
    // nothing placed cannot be complete
    `PCTS_ASSERT_NOW(a_empty_incomplete, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, !o_m_tdata[8])
endmodule

bind precedence_check_and_topo_sort_core pcts_checker u_pcts_checker (.*);

// ===== verif/tb_top.sv =====
// Testbench for the precedence check and topological sort core
`timescale 1ns / 1ps
module tb_top;
    import pcts_pkg::*;

    localparam logic RT_RULE = 1'b0;
    localparam logic RT_PAGE = 1'b1;
    localparam int N_RAND = 390;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic       rtype;
        logic [6:0] bp;
        logic [6:0] ap;
        logic [6:0] pg;
        logic       lastp;
    } t_req;

    typedef struct packed {
        logic [6:0] spage;
        logic       pvalid;
        logic       ordr;
        logic       comp;
        logic       fin;
    } t_sorted;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] i_s_tdata = '0;
    logic                i_s_tuser = 1'b0;
    logic                i_s_tlast = 1'b0;
    logic                i_m_tready = 1'b0;
    logic                o_s_tready, o_m_tvalid, o_m_tuser, o_m_tlast;
    logic [M_DATA_W-1:0] o_m_tdata;

    precedence_check_and_topo_sort_core dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    bit         prec[128][128];
    logic [6:0] upd_pages[32];
    int         upd_len;
    bit         upd_err;
    t_sorted    sorted_q[$];
    int         n_err;
    longint     cyc;

    task automatic predict_item(input t_req r);
        int n, i, j, pick, np;
        bit ord, comp;
        bit done[32];
        int pend[32];
        logic [6:0] ordl[32];
        bit dup;
        t_sorted s;
        if (r.rtype == RT_RULE) begin
            prec[r.bp][r.ap] = 1'b1;
            return;
        end
        dup = 1'b0;
        for (i = 0; i < upd_len; i++) if (upd_pages[i] == r.pg) dup = 1'b1;
        if (dup || upd_len >= 32) upd_err = 1'b1;
        else begin
            upd_pages[upd_len] = r.pg;
            upd_len++;
        end
        if (!r.lastp) return;
        n = upd_len;
        ord = 1'b1;
        for (i = 0; i < n; i++)
            for (j = i + 1; j < n; j++)
                if (prec[upd_pages[j]][upd_pages[i]]) ord = 1'b0;
        for (j = 0; j < n; j++) begin
            done[j] = 1'b0;
            pend[j] = 0;
            for (i = 0; i < n; i++) if (prec[upd_pages[i]][upd_pages[j]]) pend[j]++;
        end
        np = 0;
        forever begin
            pick = n;
            for (j = 0; j < n; j++)
                if (!done[j] && pend[j] == 0) begin
                    pick = j;
                    break;
                end
            if (pick >= n) break;
            done[pick] = 1'b1;
            ordl[np] = upd_pages[pick];
            np++;
            for (j = 0; j < n; j++)
                if (!done[j] && pend[j] > 0 &&
                    prec[upd_pages[pick]][upd_pages[j]]) pend[j]--;
        end
        comp = !upd_err && np == n;
        if (np == 0) begin
            s = '{7'd0, 1'b0, ord, comp, 1'b1};
            sorted_q = {sorted_q, s};
        end else
            for (i = 0; i < np; i++) begin
                s = '{ordl[i], 1'b1, ord, comp, i == np - 1};
                sorted_q = {sorted_q, s};
            end
        upd_len = 0;
        upd_err = 1'b0;
    endtask

    task automatic note_mismatch(input t_sorted e, input t_sorted a);
        n_err++;
        if (n_err <= 10)
            $display({"mismatch: exp page=%0d v=%0b ord=%0b comp=%0b last=%0b, ",
                      "got page=%0d v=%0b ord=%0b comp=%0b last=%0b"},
                e.spage, e.pvalid, e.ordr, e.comp, e.fin,
                a.spage, a.pvalid, a.ordr, a.comp, a.fin);
    endtask

    // receiver: own stall pattern, stretches with no stall
    always @(posedge i_clk) begin
        t_sorted a, e;
        cyc <= cyc + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            a = '{o_m_tdata[6:0], o_m_tuser, o_m_tdata[7], o_m_tdata[8], o_m_tlast};
            if (sorted_q.size() == 0) begin
                e = '0;
                note_mismatch(e, a);
            end else begin
                e = sorted_q.pop_front();
                if (a !== e) note_mismatch(e, a);
            end
        end
        if (!i_rst_n) i_m_tready <= 1'b0;
        else if ((cyc / 400) % 3 == 0) i_m_tready <= 1'b1;
        else i_m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        if (cyc > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    int burst_left;

    task automatic send_item(input t_req r);
        int g;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            g = $urandom_range(0, 6);
            if (g > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= r.rtype;
        i_s_tlast  <= r.lastp;
        i_s_tdata  <= {3'b000, r.pg, r.ap, r.bp};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_item(r);
    endtask

    function automatic t_req rule_item(input int b, input int a);
        t_req r;
        r = '{RT_RULE, b[6:0], a[6:0], 7'($urandom), 1'($urandom)};
        return r;
    endfunction

    function automatic t_req page_item(input int p, input bit l);
        t_req r;
        r = '{RT_PAGE, 7'($urandom), 7'($urandom), p[6:0], l};
        return r;
    endfunction

    t_req dir_tbl[$];

    initial begin
        t_req r;
        int i, k, len, base, nrule;
        n_err = 0;
        cyc = 0;
        burst_left = 0;
        upd_len = 0;
        upd_err = 1'b0;
        foreach (prec[a, b]) prec[a][b] = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single page, extremes, self rule, cycle, duplicate, order break
        dir_tbl = '{
            page_item(0, 1),
            page_item(127, 1),
            rule_item(127, 0),
            page_item(0, 0), page_item(127, 1),
            rule_item(5, 5),
            page_item(5, 1),
            rule_item(10, 11), rule_item(11, 10),
            page_item(10, 0), page_item(11, 0), page_item(12, 1),
            page_item(20, 0), page_item(20, 0), page_item(21, 1),
            rule_item(30, 31), page_item(30, 0), rule_item(31, 32),
            page_item(32, 0), page_item(31, 1)
        };
        foreach (dir_tbl[i]) send_item(dir_tbl[i]);
        // overflow: 34 pages
        for (i = 0; i < 34; i++) send_item(page_item(40 + i, i == 33));

        // random: mostly well-formed updates over a small page window
        k = 0;
        while (k < N_RAND) begin
            base = $urandom_range(0, 127);
            nrule = $urandom_range(0, 8);
            for (i = 0; i < nrule; i++) begin
                send_item(rule_item((base + $urandom_range(0, 15)) % 128,
                                    (base + $urandom_range(0, 15)) % 128));
                k++;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 8);
            for (i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(rule_item($urandom_range(0, 127), $urandom_range(0, 127)));
                send_item(page_item(($urandom_range(0, 11) == 0) ? $urandom_range(0, 127)
                                    : (base + $urandom_range(0, 15)) % 128, i == len - 1));
                k++;
            end
        end
        i_s_tvalid <= 1'b0;

        while (sorted_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_err == 0 && sorted_q.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
